FILE: hdl/bpsw_pkg.sv
// Shared constants, types and modular helper functions for the BPSW test unit.
package bpsw_pkg;

  localparam int NUMBER_WIDTH      = 64;
  localparam int TRIAL_PRIME_COUNT = 168;
  localparam int MAX_D_TRIES       = 64;
  localparam int MAX_W             = 64;
  localparam int PRIME_TABLE_SIZE  = 168;

  // Verdict source codes.
  localparam logic [2:0] DEC_TRIAL  = 3'd0;
  localparam logic [2:0] DEC_SMALL  = 3'd1;
  localparam logic [2:0] DEC_MR     = 3'd2;
  localparam logic [2:0] DEC_LUCAS  = 3'd3;
  localparam logic [2:0] DEC_PASSED = 3'd4;

  // Status of a multi-cycle arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam logic [9:0] SMALL_PRIMES [0:PRIME_TABLE_SIZE-1] = '{
    10'd2, 10'd3, 10'd5, 10'd7, 10'd11, 10'd13, 10'd17, 10'd19, 10'd23, 10'd29,
    10'd31, 10'd37, 10'd41, 10'd43, 10'd47, 10'd53, 10'd59, 10'd61, 10'd67, 10'd71,
    10'd73, 10'd79, 10'd83, 10'd89, 10'd97, 10'd101, 10'd103, 10'd107, 10'd109,
    10'd113, 10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163,
    10'd167, 10'd173, 10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211,
    10'd223, 10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
    10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311, 10'd313,
    10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359, 10'd367, 10'd373,
    10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409, 10'd419, 10'd421, 10'd431,
    10'd433, 10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463, 10'd467, 10'd479,
    10'd487, 10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541, 10'd547,
    10'd557, 10'd563, 10'd569, 10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601,
    10'd607, 10'd613, 10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653,
    10'd659, 10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
    10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769, 10'd773,
    10'd787, 10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827, 10'd829, 10'd839,
    10'd853, 10'd857, 10'd859, 10'd863, 10'd877, 10'd881, 10'd883, 10'd887, 10'd907,
    10'd911, 10'd919, 10'd929, 10'd937, 10'd941, 10'd947, 10'd953, 10'd967, 10'd971,
    10'd977, 10'd983, 10'd991, 10'd997
  };

  // (a + b) mod m for residues a, b below m.
  function automatic logic [MAX_W-1:0] add_m(input logic [MAX_W-1:0] a,
                                             input logic [MAX_W-1:0] b,
                                             input logic [MAX_W-1:0] m);
    logic [MAX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MAX_W-1:0];
  endfunction

  // (a - b) mod m for residues a, b below m.
  function automatic logic [MAX_W-1:0] sub_m(input logic [MAX_W-1:0] a,
                                             input logic [MAX_W-1:0] b,
                                             input logic [MAX_W-1:0] m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  // x / 2 mod m for odd m.
  function automatic logic [MAX_W-1:0] half_m(input logic [MAX_W-1:0] x,
                                              input logic [MAX_W-1:0] m);
    return x[0] ? (x >> 1) + (m >> 1) + MAX_W'(1) : x >> 1;
  endfunction

endpackage

FILE: hdl/bpsw_prime_test_unit.sv
// Top level: Baillie-PSW test sequencer around shared bit-serial arithmetic units.
//
//   channel | direction | ports                                  | transfer when
//   in      | input     | in_valid, in_stall, in_number          | in_valid && !in_stall
//   out     | output    | out_valid, out_stall, out_is_prime,    | out_valid && !out_stall
//           |           | out_decided_by                         |
//
// One number is worked on at a time. Trial division runs one remainder pass per table
// prime, so a number with a small factor leaves early and one that clears the whole
// table runs a pass for every table prime. Each modular product runs on the one
// bit-serial multiplier, which sets the rate of the later stages up to the Lucas test.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// A new number is taken while the previous verdict still waits in the output register;
// the sequencer holds its verdict until that register is free.
module bpsw_prime_test_unit #(
  parameter int NUMBER_WIDTH      = bpsw_pkg::NUMBER_WIDTH,
  parameter int TRIAL_PRIME_COUNT = bpsw_pkg::TRIAL_PRIME_COUNT,
  parameter int MAX_D_TRIES       = bpsw_pkg::MAX_D_TRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_prime,
  output logic [2:0]  out_decided_by
);

  localparam int W    = NUMBER_WIDTH;
  localparam int TC   = TRIAL_PRIME_COUNT;
  localparam int IW   = $clog2(TC + 1);
  localparam int CW   = $clog2(W + 1);
  localparam int DW   = $clog2(2 * MAX_D_TRIES + 4) + 1;
  localparam int TW   = $clog2(MAX_D_TRIES + 1);
  localparam logic [63:0] LAST_SQ =
    64'(bpsw_pkg::SMALL_PRIMES[TC-1]) * 64'(bpsw_pkg::SMALL_PRIMES[TC-1]);
  localparam int NS = 40;

  typedef enum logic [NS-1:0] {
    S_IDLE    = 40'd1 << 0,  S_TR_GO   = 40'd1 << 1,  S_TR_WAIT = 40'd1 << 2,
    S_MR_INIT = 40'd1 << 3,  S_MR_SPLIT= 40'd1 << 4,  S_MR_POW  = 40'd1 << 5,
    S_MR_RB   = 40'd1 << 6,  S_MR_SQB  = 40'd1 << 7,  S_MR_BB   = 40'd1 << 8,
    S_MR_CHK  = 40'd1 << 9,  S_MR_LOOP = 40'd1 << 10, S_MR_LX   = 40'd1 << 11,
    S_LU_SQ   = 40'd1 << 12, S_LU_SQW  = 40'd1 << 13, S_LU_D    = 40'd1 << 14,
    S_LU_DW   = 40'd1 << 15, S_JA_LOOP = 40'd1 << 16, S_JA_MODW = 40'd1 << 17,
    S_JA_END  = 40'd1 << 18, S_LU_Q    = 40'd1 << 19, S_LU_QW   = 40'd1 << 20,
    S_LU_T    = 40'd1 << 21, S_LU_TS   = 40'd1 << 22, S_LU_NORM = 40'd1 << 23,
    S_LU_BIT  = 40'd1 << 24, S_LU_U    = 40'd1 << 25, S_LU_V1   = 40'd1 << 26,
    S_LU_V2   = 40'd1 << 27, S_LU_QK   = 40'd1 << 28, S_LU_H1   = 40'd1 << 29,
    S_LU_H2   = 40'd1 << 30, S_LU_H3   = 40'd1 << 31, S_LU_QM   = 40'd1 << 32,
    S_LU_CHK  = 40'd1 << 33, S_LU_LOOP = 40'd1 << 34, S_LU_L1   = 40'd1 << 35,
    S_LU_L2   = 40'd1 << 36, S_LU_L3   = 40'd1 << 37, S_MULW    = 40'd1 << 38,
    S_FIN     = 40'd1 << 39
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [W-1:0] n_r, n_nxt;
  logic [W-1:0] x_r, x_nxt, b_r, b_nxt, d_r, d_nxt;
  logic [W-1:0] u_r, u_nxt, v_r, v_nxt, qk_r, qk_nxt, qm_r, qm_nxt, dm_r, dm_nxt;
  logic [W-1:0] tmp_r, tmp_nxt, w_r, w_nxt, ja_r, ja_nxt, jn_r, jn_nxt;
  logic [CW-1:0] s_r, s_nxt, cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [TW-1:0] tries_r, tries_nxt;
  logic signed [DW-1:0] dval_r, dval_nxt;
  logic         sign_r, sign_nxt, bit_r, bit_nxt;
  logic         res_prime_r, res_prime_nxt;
  logic [2:0]   res_dec_r, res_dec_nxt;
  logic         out_valid_r, out_valid_nxt, out_prime_r, out_prime_nxt;
  logic [2:0]   out_dec_r, out_dec_nxt;

  logic [W-1:0] mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic         mul_go_r, mul_go_nxt;
  logic [W-1:0] red_x_r, red_x_nxt, red_m_r, red_m_nxt;
  logic         red_go_r, red_go_nxt;
  logic         sq_go_r, sq_go_nxt;

  bpsw_pkg::unit_stat_t mul_stat, red_stat, sq_stat;
  logic [W-1:0] mul_prod, red_rem;
  logic         sq_flag;

  logic [W-1:0]         prime_w, nm1, dmag_w, qmag_w, neg_fix;
  logic [DW-1:0]        dmag;
  logic signed [DW:0]   omd, qv;
  logic [DW:0]          qmag;

  // Shared arithmetic units.
  bpsw_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .go(mul_go_r), .a(mul_a_r), .b(mul_b_r), .m(n_r),
    .stat(mul_stat), .prod(mul_prod)
  );

  bpsw_modred #(.W(W)) u_red (
    .clk(clk), .rst_n(rst_n), .go(red_go_r), .x(red_x_r), .m(red_m_r),
    .stat(red_stat), .rem(red_rem)
  );

  bpsw_isqrt #(.W(W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .go(sq_go_r), .x(n_r), .stat(sq_stat), .square(sq_flag)
  );

  // Small derived values for trial division and the Selfridge search.
  always_comb begin
    prime_w = W'(bpsw_pkg::SMALL_PRIMES[8'(idx_r)]);
    nm1     = n_r - W'(1);
    dmag    = dval_r[DW-1] ? DW'(-dval_r) : DW'(dval_r);
    dmag_w  = W'(dmag);
    omd     = $signed((DW+1)'(1)) - $signed((DW+1)'(dval_r));
    qv      = omd >>> 2;
    qmag    = qv[DW] ? (DW+1)'(-qv) : (DW+1)'(qv);
    qmag_w  = W'(qmag);
    neg_fix = n_r - red_rem;
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    n_nxt         = n_r;
    x_nxt         = x_r;
    b_nxt         = b_r;
    d_nxt         = d_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    qk_nxt        = qk_r;
    qm_nxt        = qm_r;
    dm_nxt        = dm_r;
    tmp_nxt       = tmp_r;
    w_nxt         = w_r;
    ja_nxt        = ja_r;
    jn_nxt        = jn_r;
    s_nxt         = s_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    tries_nxt     = tries_r;
    dval_nxt      = dval_r;
    sign_nxt      = sign_r;
    bit_nxt       = bit_r;
    res_prime_nxt = res_prime_r;
    res_dec_nxt   = res_dec_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    mul_go_nxt    = 1'b0;
    red_x_nxt     = red_x_r;
    red_m_nxt     = red_m_r;
    red_go_nxt    = 1'b0;
    sq_go_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    out_dec_nxt   = out_dec_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt     = in_number[W-1:0];
          idx_nxt   = '0;
          state_nxt = S_TR_GO;
        end
      end

      // Trial division, one table prime per remainder pass.
      S_TR_GO: begin
        if (n_r < W'(2)) begin
          res_prime_nxt = 1'b0;
          res_dec_nxt   = bpsw_pkg::DEC_TRIAL;
          state_nxt     = S_FIN;
        end else begin
          red_x_nxt  = n_r;
          red_m_nxt  = prime_w;
          red_go_nxt = 1'b1;
          state_nxt  = S_TR_WAIT;
        end
      end

      S_TR_WAIT: begin
        if (red_stat.done) begin
          if (n_r == prime_w) begin
            res_prime_nxt = 1'b1;
            res_dec_nxt   = bpsw_pkg::DEC_SMALL;
            state_nxt     = S_FIN;
          end else if (red_rem == '0) begin
            res_prime_nxt = 1'b0;
            res_dec_nxt   = bpsw_pkg::DEC_TRIAL;
            state_nxt     = S_FIN;
          end else if (idx_r == IW'(TC - 1)) begin
            if (64'(n_r) < LAST_SQ) begin
              res_prime_nxt = 1'b1;
              res_dec_nxt   = bpsw_pkg::DEC_SMALL;
              state_nxt     = S_FIN;
            end else begin
              state_nxt = S_MR_INIT;
            end
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_TR_GO;
          end
        end
      end

      // Miller-Rabin to base 2: split n - 1, then right-to-left power.
      S_MR_INIT: begin
        d_nxt     = nm1;
        s_nxt     = '0;
        state_nxt = S_MR_SPLIT;
      end

      S_MR_SPLIT: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + CW'(1);
        end else begin
          x_nxt     = W'(1);
          b_nxt     = W'(2);
          state_nxt = S_MR_POW;
        end
      end

      S_MR_POW: begin
        if (d_r == '0) begin
          state_nxt = S_MR_CHK;
        end else if (d_r[0]) begin
          mul_a_nxt  = x_r;
          mul_b_nxt  = b_r;
          mul_go_nxt = 1'b1;
          ret_nxt    = S_MR_RB;
          state_nxt  = S_MULW;
        end else begin
          state_nxt = S_MR_SQB;
        end
      end

      S_MR_RB: begin
        x_nxt     = mul_prod;
        state_nxt = S_MR_SQB;
      end

      S_MR_SQB: begin
        mul_a_nxt  = b_r;
        mul_b_nxt  = b_r;
        mul_go_nxt = 1'b1;
        ret_nxt    = S_MR_BB;
        state_nxt  = S_MULW;
      end

      S_MR_BB: begin
        b_nxt     = mul_prod;
        d_nxt     = d_r >> 1;
        state_nxt = S_MR_POW;
      end

      S_MR_CHK: begin
        if (x_r == W'(1) || x_r == nm1) begin
          state_nxt = S_LU_SQ;
        end else begin
          cnt_nxt   = CW'(1);
          state_nxt = S_MR_LOOP;
        end
      end

      S_MR_LOOP: begin
        if (cnt_r < s_r) begin
          mul_a_nxt  = x_r;
          mul_b_nxt  = x_r;
          mul_go_nxt = 1'b1;
          ret_nxt    = S_MR_LX;
          state_nxt  = S_MULW;
        end else begin
          res_prime_nxt = 1'b0;
          res_dec_nxt   = bpsw_pkg::DEC_MR;
          state_nxt     = S_FIN;
        end
      end

      S_MR_LX: begin
        x_nxt   = mul_prod;
        cnt_nxt = cnt_r + CW'(1);
        if (mul_prod == nm1) begin
          state_nxt = S_LU_SQ;
        end else begin
          state_nxt = S_MR_LOOP;
        end
      end

      // Strong Lucas: reject perfect squares first.
      S_LU_SQ: begin
        sq_go_nxt = 1'b1;
        state_nxt = S_LU_SQW;
      end

      S_LU_SQW: begin
        if (sq_stat.done) begin
          if (sq_flag) begin
            res_prime_nxt = 1'b0;
            res_dec_nxt   = bpsw_pkg::DEC_LUCAS;
            state_nxt     = S_FIN;
          end else begin
            tries_nxt = '0;
            dval_nxt  = DW'(5);
            state_nxt = S_LU_D;
          end
        end
      end

      // Selfridge search: reduce D into [0, n), then the Jacobi symbol.
      S_LU_D: begin
        red_x_nxt  = dmag_w;
        red_m_nxt  = n_r;
        red_go_nxt = 1'b1;
        state_nxt  = S_LU_DW;
      end

      S_LU_DW: begin
        if (red_stat.done) begin
          if (dval_r[DW-1] && red_rem != '0) begin
            dm_nxt = neg_fix;
            ja_nxt = neg_fix;
          end else begin
            dm_nxt = red_rem;
            ja_nxt = red_rem;
          end
          jn_nxt    = n_r;
          sign_nxt  = 1'b0;
          state_nxt = S_JA_LOOP;
        end
      end

      S_JA_LOOP: begin
        if (ja_r == '0) begin
          state_nxt = S_JA_END;
        end else if (!ja_r[0]) begin
          ja_nxt = ja_r >> 1;
          if (jn_r[2:0] == 3'd3 || jn_r[2:0] == 3'd5) begin
            sign_nxt = !sign_r;
          end
        end else begin
          ja_nxt = jn_r;
          jn_nxt = ja_r;
          if (ja_r[1:0] == 2'd3 && jn_r[1:0] == 2'd3) begin
            sign_nxt = !sign_r;
          end
          red_x_nxt  = jn_r;
          red_m_nxt  = ja_r;
          red_go_nxt = 1'b1;
          state_nxt  = S_JA_MODW;
        end
      end

      S_JA_MODW: begin
        if (red_stat.done) begin
          ja_nxt    = red_rem;
          state_nxt = S_JA_LOOP;
        end
      end

      S_JA_END: begin
        if (jn_r == W'(1) && sign_r) begin
          state_nxt = S_LU_Q;
        end else if (jn_r != W'(1) && dmag_w != n_r) begin
          res_prime_nxt = 1'b0;
          res_dec_nxt   = bpsw_pkg::DEC_LUCAS;
          state_nxt     = S_FIN;
        end else if (tries_r == TW'(MAX_D_TRIES - 1)) begin
          res_prime_nxt = 1'b0;
          res_dec_nxt   = bpsw_pkg::DEC_LUCAS;
          state_nxt     = S_FIN;
        end else begin
          tries_nxt = tries_r + TW'(1);
          dval_nxt  = dval_r[DW-1] ? DW'(-dval_r + DW'(2)) : DW'(-(dval_r + DW'(2)));
          state_nxt = S_LU_D;
        end
      end

      // Q = (1 - D) / 4 reduced into [0, n).
      S_LU_Q: begin
        red_x_nxt  = qmag_w;
        red_m_nxt  = n_r;
        red_go_nxt = 1'b1;
        state_nxt  = S_LU_QW;
      end

      S_LU_QW: begin
        if (red_stat.done) begin
          qm_nxt    = (qv[DW] && red_rem != '0) ? neg_fix : red_rem;
          state_nxt = S_LU_T;
        end
      end

      // n + 1 = t * 2^s, then align t so its top bit leads.
      S_LU_T: begin
        d_nxt     = (n_r >> 1) + W'(1);
        s_nxt     = CW'(1);
        state_nxt = S_LU_TS;
      end

      S_LU_TS: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + CW'(1);
        end else begin
          cnt_nxt   = CW'(W);
          state_nxt = S_LU_NORM;
        end
      end

      S_LU_NORM: begin
        if (!d_r[W-1]) begin
          d_nxt   = d_r << 1;
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          u_nxt     = W'(1);
          v_nxt     = W'(1);
          qk_nxt    = qm_r;
          state_nxt = S_LU_BIT;
        end
      end

      // One bit of t: double the index, then add one if the bit is set.
      S_LU_BIT: begin
        if (cnt_r == '0) begin
          state_nxt = S_LU_CHK;
        end else begin
          d_nxt      = d_r << 1;
          bit_nxt    = d_r[W-2];
          cnt_nxt    = cnt_r - CW'(1);
          mul_a_nxt  = u_r;
          mul_b_nxt  = v_r;
          mul_go_nxt = 1'b1;
          ret_nxt    = S_LU_U;
          state_nxt  = S_MULW;
        end
      end

      S_LU_U: begin
        u_nxt      = mul_prod;
        mul_a_nxt  = v_r;
        mul_b_nxt  = v_r;
        mul_go_nxt = 1'b1;
        ret_nxt    = S_LU_V1;
        state_nxt  = S_MULW;
      end

      S_LU_V1: begin
        tmp_nxt   = mul_prod;
        w_nxt     = W'(bpsw_pkg::add_m(64'(qk_r), 64'(qk_r), 64'(n_r)));
        state_nxt = S_LU_V2;
      end

      S_LU_V2: begin
        v_nxt      = W'(bpsw_pkg::sub_m(64'(tmp_r), 64'(w_r), 64'(n_r)));
        mul_a_nxt  = qk_r;
        mul_b_nxt  = qk_r;
        mul_go_nxt = 1'b1;
        ret_nxt    = S_LU_QK;
        state_nxt  = S_MULW;
      end

      S_LU_QK: begin
        qk_nxt = mul_prod;
        if (bit_r) begin
          mul_a_nxt  = dm_r;
          mul_b_nxt  = u_r;
          mul_go_nxt = 1'b1;
          ret_nxt    = S_LU_H1;
          state_nxt  = S_MULW;
        end else begin
          state_nxt = S_LU_BIT;
        end
      end

      S_LU_H1: begin
        tmp_nxt   = mul_prod;
        w_nxt     = W'(bpsw_pkg::add_m(64'(u_r), 64'(v_r), 64'(n_r)));
        state_nxt = S_LU_H2;
      end

      S_LU_H2: begin
        u_nxt     = W'(bpsw_pkg::half_m(64'(w_r), 64'(n_r)));
        w_nxt     = W'(bpsw_pkg::add_m(64'(tmp_r), 64'(v_r), 64'(n_r)));
        state_nxt = S_LU_H3;
      end

      S_LU_H3: begin
        v_nxt      = W'(bpsw_pkg::half_m(64'(w_r), 64'(n_r)));
        mul_a_nxt  = qk_r;
        mul_b_nxt  = qm_r;
        mul_go_nxt = 1'b1;
        ret_nxt    = S_LU_QM;
        state_nxt  = S_MULW;
      end

      S_LU_QM: begin
        qk_nxt    = mul_prod;
        state_nxt = S_LU_BIT;
      end

      // Strong check: U or V zero, or some V doubled up to s - 1 times is zero.
      S_LU_CHK: begin
        if (u_r == '0 || v_r == '0) begin
          res_prime_nxt = 1'b1;
          res_dec_nxt   = bpsw_pkg::DEC_PASSED;
          state_nxt     = S_FIN;
        end else begin
          cnt_nxt   = CW'(1);
          state_nxt = S_LU_LOOP;
        end
      end

      S_LU_LOOP: begin
        if (cnt_r < s_r) begin
          mul_a_nxt  = v_r;
          mul_b_nxt  = v_r;
          mul_go_nxt = 1'b1;
          ret_nxt    = S_LU_L1;
          state_nxt  = S_MULW;
        end else begin
          res_prime_nxt = 1'b0;
          res_dec_nxt   = bpsw_pkg::DEC_LUCAS;
          state_nxt     = S_FIN;
        end
      end

      S_LU_L1: begin
        tmp_nxt   = mul_prod;
        w_nxt     = W'(bpsw_pkg::add_m(64'(qk_r), 64'(qk_r), 64'(n_r)));
        state_nxt = S_LU_L2;
      end

      S_LU_L2: begin
        v_nxt      = W'(bpsw_pkg::sub_m(64'(tmp_r), 64'(w_r), 64'(n_r)));
        mul_a_nxt  = qk_r;
        mul_b_nxt  = qk_r;
        mul_go_nxt = 1'b1;
        ret_nxt    = S_LU_L3;
        state_nxt  = S_MULW;
      end

      S_LU_L3: begin
        qk_nxt  = mul_prod;
        cnt_nxt = cnt_r + CW'(1);
        if (v_r == '0) begin
          res_prime_nxt = 1'b1;
          res_dec_nxt   = bpsw_pkg::DEC_PASSED;
          state_nxt     = S_FIN;
        end else begin
          state_nxt = S_LU_LOOP;
        end
      end

      // Wait for a product, then resume where the product is consumed.
      S_MULW: begin
        if (mul_stat.done) begin
          state_nxt = ret_r;
        end
      end

      // Hand the verdict to the output register once it is free.
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_prime_r;
          out_dec_nxt   = res_dec_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      mul_go_r    <= 1'b0;
      red_go_r    <= 1'b0;
      sq_go_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      mul_go_r    <= mul_go_nxt;
      red_go_r    <= red_go_nxt;
      sq_go_r     <= sq_go_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    x_r         <= x_nxt;
    b_r         <= b_nxt;
    d_r         <= d_nxt;
    u_r         <= u_nxt;
    v_r         <= v_nxt;
    qk_r        <= qk_nxt;
    qm_r        <= qm_nxt;
    dm_r        <= dm_nxt;
    tmp_r       <= tmp_nxt;
    w_r         <= w_nxt;
    ja_r        <= ja_nxt;
    jn_r        <= jn_nxt;
    s_r         <= s_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    tries_r     <= tries_nxt;
    dval_r      <= dval_nxt;
    sign_r      <= sign_nxt;
    bit_r       <= bit_nxt;
    res_prime_r <= res_prime_nxt;
    res_dec_r   <= res_dec_nxt;
    out_prime_r <= out_prime_nxt;
    out_dec_r   <= out_dec_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    red_x_r     <= red_x_nxt;
    red_m_r     <= red_m_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_is_prime   = out_prime_r;
  assign out_decided_by = out_dec_r;

  // The verdict bit agrees with the stage that decided it.
  a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_prime == (out_decided_by == bpsw_pkg::DEC_SMALL ||
                                    out_decided_by == bpsw_pkg::DEC_PASSED)))
    else $error("verdict bit disagrees with deciding stage");

  // A multiplier start never lands on a product still in progress.
  a_mul_idle_on_go: assert property (@(posedge clk) disable iff (!rst_n)
    mul_go_r |-> !mul_stat.busy)
    else $error("multiplier restarted while busy");

  // A remainder pass never starts while another is running.
  a_red_idle_on_go: assert property (@(posedge clk) disable iff (!rst_n)
    red_go_r |-> !red_stat.busy)
    else $error("remainder unit restarted while busy");

  // A new verdict is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_decided_by)))
    else $error("stalled verdict overwritten");

endmodule

FILE: hdl/bpsw_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module bpsw_mulmod #(
  parameter int W = bpsw_pkg::NUMBER_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [W-1:0]         a,
  input  logic [W-1:0]         b,
  input  logic [W-1:0]         m,
  output bpsw_pkg::unit_stat_t stat,
  output logic [W-1:0]         prod
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  a_r, b_r, m_r, acc_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W+1:0]  x, m1, m2;
  logic [W+1:0]  step;

  // Double the accumulator, add the multiplicand when the bit is set, reduce.
  always_comb begin
    x  = ({2'b00, acc_r} << 1) + (b_r[W-1] ? {2'b00, a_r} : '0);
    m1 = {2'b00, m_r};
    m2 = m1 << 1;
    if (x >= m2) begin
      step = x - m2;
    end else if (x >= m1) begin
      step = x - m1;
    end else begin
      step = x;
    end
  end

  // Operand capture and iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r   <= a;
      b_r   <= b;
      m_r   <= m;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= step[W-1:0];
      b_r   <= b_r << 1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

FILE: hdl/bpsw_modred.sv
// Bit-serial remainder unit: x mod m by restoring division, one bit per cycle.
module bpsw_modred #(
  parameter int W = bpsw_pkg::NUMBER_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [W-1:0]         x,
  input  logic [W-1:0]         m,
  output bpsw_pkg::unit_stat_t stat,
  output logic [W-1:0]         rem
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  x_r, m_r, rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    r2;
  logic [W:0]    r_step;

  // Shift in the next dividend bit and subtract the modulus if it fits.
  always_comb begin
    r2 = {rem_r, x_r[W-1]};
    if (r2 >= {1'b0, m_r}) begin
      r_step = r2 - {1'b0, m_r};
    end else begin
      r_step = r2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r   <= x;
      m_r   <= m;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= r_step[W-1:0];
      x_r   <= x_r << 1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

FILE: hdl/bpsw_isqrt.sv
// Digit-serial integer square root, two radicand bits per cycle; flags perfect squares.
module bpsw_isqrt #(
  parameter int W = bpsw_pkg::NUMBER_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [W-1:0]         x,
  output bpsw_pkg::unit_stat_t stat,
  output logic                 square
);

  localparam int W2 = W + (W % 2);
  localparam int H  = W2 / 2;
  localparam int RW = H + 3;
  localparam int CW = $clog2(H + 1);

  logic [W2-1:0] x_r;
  logic [H-1:0]  root_r;
  logic [RW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [RW-1:0] r4, trial;

  // Bring down two bits and try to subtract 4*root + 1.
  always_comb begin
    r4    = {rem_r[RW-3:0], x_r[W2-1:W2-2]};
    trial = RW'({root_r, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(H - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r    <= W2'(x);
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      x_r <= x_r << 2;
      if (r4 >= trial) begin
        rem_r  <= r4 - trial;
        root_r <= {root_r[H-2:0], 1'b1};
      end else begin
        rem_r  <= r4;
        root_r <= {root_r[H-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign square    = (rem_r == '0);

endmodule
